// ----- hw/rtl/five_point_laplacian_stencil_macros.svh -----
// assertion helpers used by the checker file
`ifndef FIVE_POINT_LAPLACIAN_STENCIL_MACROS_SVH
`define FIVE_POINT_LAPLACIAN_STENCIL_MACROS_SVH

// property sampled on the rising clock, off while reset is held
`define FPLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expression that must never be true
`define FPLS_ASSERT_NEVER(lbl, expr, msg) \
    `FPLS_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/fpls_pkg.sv -----
`default_nettype none

package fpls_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int COL_BITS     = ADDR_BITS;
    localparam int WIDTH_BITS   = ADDR_BITS + 1;
    localparam int VALUE_BITS   = 32;
    localparam int OUT_BITS     = VALUE_BITS + 3;
    localparam int ROW_BITS     = 16;
    localparam int ROW_CNT_BITS = ROW_BITS + 1;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCAL_ROWS = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_UPPER  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_LOWER  = 4'd3;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(MAX_WIDTH);

    // stream row whose samples complete the first local row (row 0 is the leading ghost row)
    localparam logic [ROW_CNT_BITS-1:0] ROW_FIRST_LOCAL = ROW_CNT_BITS'(2);

    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic [COL_BITS-1:0]        col;
        logic [ROW_BITS-1:0]        row;
        logic                       last;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/fpls_ram.sv -----
`default_nettype none

module fpls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/five_point_laplacian_stencil.sv -----
// Five-point Laplacian stencil over a grid slab streamed in row-major order.
// Sample channel: i_sample_valid / o_sample_ready carry one signed Q16.16 value
// per request: a leading ghost row, local_rows local rows, a trailing ghost row.
// Result channel: o_result_valid / i_result_ready carry 4*centre minus the four
// neighbours with the column, local row and a last flag for the slab end.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
// always ready; write only while the block is idle.
// The result for a point is formed when the sample directly below it is
// accepted, and is registered for output. Throughput is one sample a cycle
// while ready is high, set by the single read port of each line memory, read
// ahead at the next column so its data is ready when the next sample arrives.
// Ready drops for one cycle after reset and after every config write while the
// read-ahead data is refetched.
// When the receiver stalls, one more result is held in a skid register and
// samples keep being taken until that register is full.
// Reset returns the config registers to their defaults and the stream position
// to the leading ghost row; the line memories are not cleared.
`default_nettype none

module five_point_laplacian_stencil (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_sample_valid,
    output logic                                           o_sample_ready,
    input  wire logic signed [fpls_pkg::VALUE_BITS-1:0]    i_sample,
    output logic                                           o_result_valid,
    input  wire logic                                      i_result_ready,
    output logic signed [fpls_pkg::OUT_BITS-1:0]           o_out_value,
    output logic [fpls_pkg::COL_BITS-1:0]                  o_out_col,
    output logic [fpls_pkg::ROW_BITS-1:0]                  o_out_row,
    output logic                                           o_out_last,
    input  wire logic                                      i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  wire logic [fpls_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  wire logic [fpls_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int VB = fpls_pkg::VALUE_BITS;
    localparam int OB = fpls_pkg::OUT_BITS;
    localparam int AB = fpls_pkg::ADDR_BITS;
    localparam int WB = fpls_pkg::WIDTH_BITS;
    localparam int RB = fpls_pkg::ROW_CNT_BITS;

    // configuration
    logic [WB-1:0]                   r_row_width;
    logic [fpls_pkg::ROW_BITS-1:0]   r_local_rows;
    logic                            r_has_upper;
    logic                            r_has_lower;
    logic                            cfg_acc;

    // stream position and read-ahead control
    logic [AB-1:0]          r_col;
    logic [RB-1:0]          r_row;
    logic [AB-1:0]          n_col;
    logic [RB-1:0]          n_row;
    logic                   r_fresh;
    logic                   r_fwd_a;
    logic                   r_fwd_b;
    logic                   n_fwd_a;
    logic                   n_fwd_b;
    logic signed [VB-1:0]   r_wr_sample;
    logic signed [VB-1:0]   r_wr_centre;
    logic signed [VB-1:0]   r_left;

    logic [WB-1:0]          w_eff;
    logic [RB-1:0]          l_last;
    logic                   restart;
    logic [AB-1:0]          c;
    logic [RB-1:0]          r;
    logic                   col_last;
    logic                   acc;
    logic [AB-1:0]          addr_a;
    logic [AB-1:0]          addr_b;

    logic [VB-1:0]          a_rd;
    logic [2*VB-1:0]        b_rd;
    logic signed [VB-1:0]   centre;
    logic signed [VB-1:0]   north;
    logic signed [VB-1:0]   east;

    logic signed [OB-1:0]   centre_x;
    logic signed [OB-1:0]   north_x;
    logic signed [OB-1:0]   south_x;
    logic signed [OB-1:0]   west_x;
    logic signed [OB-1:0]   east_x;
    logic                   has_result;
    fpls_pkg::t_result      res;

    // output register and skid
    fpls_pkg::t_result      r_out;
    fpls_pkg::t_result      r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic                   push;
    logic                   out_free;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= fpls_pkg::WIDTH_RESET;
            r_local_rows <= fpls_pkg::ROW_BITS'(1);
            r_has_upper  <= 1'b0;
            r_has_lower  <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                fpls_pkg::CFG_ROW_WIDTH:  r_row_width  <= i_cfg_data[WB-1:0];
                fpls_pkg::CFG_LOCAL_ROWS: r_local_rows <= i_cfg_data[fpls_pkg::ROW_BITS-1:0];
                fpls_pkg::CFG_HAS_UPPER:  r_has_upper  <= i_cfg_data[0];
                fpls_pkg::CFG_HAS_LOWER:  r_has_lower  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp width and row count, fold an out-of-range position back to the start
    always_comb begin
        if (r_row_width == '0) begin
            w_eff = WB'(1);
        end else if (r_row_width > fpls_pkg::WIDTH_RESET) begin
            w_eff = fpls_pkg::WIDTH_RESET;
        end else begin
            w_eff = r_row_width;
        end
        if (r_local_rows == '0) begin
            l_last = RB'(2);
        end else begin
            l_last = RB'(r_local_rows) + RB'(1);
        end
        restart  = ({1'b0, r_col} >= w_eff) || (r_row > l_last);
        c        = restart ? '0 : r_col;
        r        = restart ? '0 : r_row;
        col_last = (WB'(c) + WB'(1)) >= w_eff;
    end

    assign o_sample_ready = r_fresh && !i_cfg_valid && !r_skid_valid;
    assign acc            = i_sample_valid && o_sample_ready;

    always_comb begin
        n_col = c;
        n_row = r;
        if (acc) begin
            if (col_last) begin
                n_col = '0;
                n_row = (r >= l_last) ? '0 : r + RB'(1);
            end else begin
                n_col = c + AB'(1);
            end
        end
        // read ahead: centre/north at the next column, east one further
        addr_b  = n_col;
        addr_a  = n_col + AB'(1);
        n_fwd_a = acc && (addr_a == c);
        n_fwd_b = acc && (addr_b == c);
    end

    // line memory A holds the previous row, B holds {older row, previous row}
    fpls_ram #(
        .WIDTH (VB),
        .DEPTH (fpls_pkg::MAX_WIDTH)
    ) u_ram_prev (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_addr (c),
        .i_wr_data (i_sample),
        .i_rd_addr (addr_a),
        .o_rd_data (a_rd)
    );

    fpls_ram #(
        .WIDTH (2 * VB),
        .DEPTH (fpls_pkg::MAX_WIDTH)
    ) u_ram_pair (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_addr (c),
        .i_wr_data ({centre, i_sample}),
        .i_rd_addr (addr_b),
        .o_rd_data (b_rd)
    );

    // forward the write of the last accepted sample over the stale read data
    always_comb begin
        centre = r_fwd_b ? r_wr_sample : b_rd[VB-1:0];
        north  = r_fwd_b ? r_wr_centre : b_rd[2*VB-1:VB];
        east   = r_fwd_a ? r_wr_sample : a_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fresh <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_fresh <= !cfg_acc;
            r_fwd_a <= n_fwd_a;
            r_fwd_b <= n_fwd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_wr_sample <= i_sample;
            r_wr_centre <= centre;
            r_left      <= centre;
        end
    end

    always_comb begin
        centre_x   = OB'(centre);
        north_x    = (r == fpls_pkg::ROW_FIRST_LOCAL && !r_has_upper) ? '0 : OB'(north);
        south_x    = (r == l_last && !r_has_lower) ? '0 : OB'(i_sample);
        west_x     = (c == '0) ? '0 : OB'(r_left);
        east_x     = col_last ? '0 : OB'(east);
        has_result = r >= fpls_pkg::ROW_FIRST_LOCAL;
        res.value  = {centre_x[OB-3:0], 2'b00} - north_x - south_x - west_x - east_x;
        res.col    = c;
        res.row    = fpls_pkg::ROW_BITS'(r - fpls_pkg::ROW_FIRST_LOCAL);
        res.last   = (r == l_last) && col_last;
    end

    assign push     = acc && has_result;
    assign out_free = !r_out_valid || i_result_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // no request is taken while the skid is full
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_out_value    = r_out.value;
    assign o_out_col      = r_out.col;
    assign o_out_row      = r_out.row;
    assign o_out_last     = r_out.last;

endmodule

`default_nettype wire

// ----- hw/rtl/fpls_checker.sv -----
`default_nettype none

`include "five_point_laplacian_stencil_macros.svh"

module fpls_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_sample_valid,
    input wire logic                                   o_sample_ready,
    input wire logic                                   o_result_valid,
    input wire logic                                   i_result_ready,
    input wire logic signed [fpls_pkg::OUT_BITS-1:0]   o_out_value,
    input wire logic                                   i_cfg_valid,
    input wire logic                                   o_cfg_ready
);

    logic stalled;
    logic cfg_acc;
    logic sample_acc;

    assign stalled    = o_result_valid && !i_result_ready;
    assign cfg_acc    = i_cfg_valid && o_cfg_ready;
    assign sample_acc = i_sample_valid && o_sample_ready;

    // result held while the receiver stalls
    `FPLS_ASSERT(a_result_held, stalled |=> o_result_valid, "result dropped while stalled")

    `FPLS_ASSERT(a_result_stable, stalled |=> $stable(o_out_value), "stalled result changed")

    // read-ahead data is refetched after a config write
    `FPLS_ASSERT(a_cfg_refetch, cfg_acc |=> !o_sample_ready, "sample ready after config write")

    // a new result only ever follows an accepted sample
    `FPLS_ASSERT(a_cause, $rose(o_result_valid) |-> $past(sample_acc), "no sample before result")

endmodule

bind five_point_laplacian_stencil fpls_checker u_fpls_checker (.*);

`default_nettype wire
